### rtl/vna_pkg.sv
// ============================================================================
// vna_pkg - shared types and constants for the vertex normal averager
// Field widths, fixed-point formats, controller/unit states and the command
// and status bundles between controller and datapath.
// ============================================================================
package vna_pkg;

  localparam int VERTEX_SLOTS_DEF = 1024;
  localparam int COUNT_BITS_DEF   = 8;

  localparam int IDX_W     = 10;  // vertex index field
  localparam int IDX_EXT_W = 17;  // holds any slot count up to 65536
  localparam int POS_W     = 16;  // Q3.12 coordinate
  localparam int NRM_W     = 16;  // Q1.14 normal component
  localparam int FRAC_W    = 14;  // fraction bits of 1.0 in Q1.14
  localparam int VEC_W     = 36;  // raw vector fed to the unit-length unit

  typedef enum logic [4:0] {
    C_CLEAR,
    C_IDLE,
    C_CHECK,
    C_RD_A,
    C_RD_B,
    C_RD_C,
    C_EDGE,
    C_PROD,
    C_CROSS,
    C_FGO,
    C_FWAIT,
    C_DEGEN,
    C_CRD,
    C_COUNT,
    C_BMUL,
    C_BADD,
    C_BGO,
    C_BWAIT,
    C_EMIT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_NORM,
    U_SQ,
    U_ROOT,
    U_DINIT,
    U_DIV,
    U_DONE
  } unit_state_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_FACE,
    SRC_UNIT,
    SRC_OLD
  } src_t;

  typedef struct packed {
    logic       load;
    logic       face_latch;
    logic       clear_step;
    logic       pos_rd;
    logic       save_pa;
    logic       save_pb;
    logic       edge_en;
    logic       prod_en;
    logic       cross_en;
    logic       blend_mul;
    logic       blend_add;
    logic       unit_start;
    logic       face_save;
    logic       corner_rd;
    logic       count_wr;
    logic       nrm_wr;
    logic       nrm_from_unit;
    logic       emit;
    logic       last;
    src_t       src;
    logic [1:0] corner;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic range_ok;
    logic unit_done;
    logic unit_zero;
    logic first_use;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/vna_unit.sv
// ============================================================================
// vna_unit - iterative unit-length scaler
// Normalizes magnitudes one bit per cycle, sums squares on one multiplier,
// takes a bit-serial square root and runs three restoring dividers in
// parallel to give a signed Q1.14 unit vector.
// ============================================================================
module vna_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [vna_pkg::VEC_W-1:0]   vec_x,
  input  logic signed [vna_pkg::VEC_W-1:0]   vec_y,
  input  logic signed [vna_pkg::VEC_W-1:0]   vec_z,
  output logic                               done,
  output logic                               zero,
  output logic signed [vna_pkg::NRM_W-1:0]   res_x,
  output logic signed [vna_pkg::NRM_W-1:0]   res_y,
  output logic signed [vna_pkg::NRM_W-1:0]   res_z
);
  import vna_pkg::*;

  localparam int HI    = 30;
  localparam int LO    = 29;
  localparam int SQ_W  = 2 * HI;
  localparam int ACC_W = 64;
  localparam int Q_W   = FRAC_W + 1;
  localparam int REM_W = HI + FRAC_W + 2;

  unit_state_t state, state_next;

  logic [VEC_W-1:0] vin [3];
  logic [VEC_W-1:0] m [3];
  logic [2:0]       neg;
  logic [SQ_W-1:0]  prod;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] r;
  logic [ACC_W-1:0] bitv;
  logic [ACC_W-1:0] trial;
  logic [1:0]       sq_cnt;
  logic [REM_W-1:0] rem [3];
  logic [REM_W-1:0] dsh;
  logic [Q_W-1:0]   q [3];
  logic [3:0]       dv_cnt;
  logic [NRM_W-1:0] qe [3];
  logic             any_big, any_ge_lo, all_zero;

  always_comb begin
    vin[0] = vec_x;
    vin[1] = vec_y;
    vin[2] = vec_z;
    any_big   = 1'b0;
    any_ge_lo = 1'b0;
    all_zero  = 1'b1;
    for (int i = 0; i < 3; i++) begin
      any_big   = any_big | (|m[i][VEC_W-1:HI]);
      any_ge_lo = any_ge_lo | (|m[i][VEC_W-1:LO]);
      all_zero  = all_zero & (m[i] == '0);
      qe[i]     = NRM_W'(q[i]);
    end
    trial = r + bitv;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      U_IDLE:  if (start) state_next = U_NORM;
      U_NORM: begin
        if (all_zero) state_next = U_DONE;
        else if (!any_big && any_ge_lo) state_next = U_SQ;
      end
      U_SQ:    if (sq_cnt == 2'd3) state_next = U_ROOT;
      U_ROOT:  if (bitv[0]) state_next = U_DINIT;
      U_DINIT: state_next = U_DIV;
      U_DIV:   if (dv_cnt == 4'(Q_W - 1)) state_next = U_DONE;
      U_DONE:  state_next = U_IDLE;
      default: state_next = U_IDLE;
    endcase
  end

  always_comb begin
    done = (state == U_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      U_IDLE: begin
        if (start) begin
          zero <= 1'b0;
          for (int i = 0; i < 3; i++) begin
            neg[i] <= vin[i][VEC_W-1];
            m[i]   <= vin[i][VEC_W-1] ? (VEC_W'(0) - vin[i]) : vin[i];
          end
        end
      end
      U_NORM: begin
        if (all_zero) begin
          zero <= 1'b1;
        end else if (any_big) begin
          for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
        end else if (!any_ge_lo) begin
          for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
        end else begin
          acc    <= '0;
          prod   <= '0;
          sq_cnt <= '0;
        end
      end
      U_SQ: begin
        acc    <= acc + ACC_W'(prod);
        sq_cnt <= sq_cnt + 2'd1;
        if (sq_cnt != 2'd3) begin
          prod <= m[sq_cnt][HI-1:0] * m[sq_cnt][HI-1:0];
        end else begin
          r    <= '0;
          bitv <= ACC_W'(1) << (ACC_W - 2);
        end
      end
      U_ROOT: begin
        if (acc >= trial) begin
          acc <= acc - trial;
          r   <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        bitv <= bitv >> 2;
      end
      U_DINIT: begin
        for (int i = 0; i < 3; i++) begin
          rem[i] <= REM_W'({m[i][HI-1:0], {FRAC_W{1'b0}}}) + REM_W'(r[ACC_W-1:1]);
          q[i]   <= '0;
        end
        dsh    <= REM_W'({r[HI:0], {FRAC_W{1'b0}}});
        dv_cnt <= '0;
      end
      U_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (rem[i] >= dsh) begin
            rem[i] <= rem[i] - dsh;
            q[i]   <= {q[i][Q_W-2:0], 1'b1};
          end else begin
            q[i] <= {q[i][Q_W-2:0], 1'b0};
          end
        end
        dsh    <= dsh >> 1;
        dv_cnt <= dv_cnt + 4'd1;
      end
      default: ;
    endcase
  end

  assign res_x = neg[0] ? (NRM_W'(0) - qe[0]) : qe[0];
  assign res_y = neg[1] ? (NRM_W'(0) - qe[1]) : qe[1];
  assign res_z = neg[2] ? (NRM_W'(0) - qe[2]) : qe[2];

endmodule

### rtl/vna_dp.sv
// ============================================================================
// vna_dp - datapath of the vertex normal averager
// Position, normal and use-count stores, edge and cross-product stages,
// blend multiply, the unit-length unit and the output register.
// ============================================================================
module vna_dp #(
  parameter int VERTEX_SLOTS = vna_pkg::VERTEX_SLOTS_DEF,
  parameter int COUNT_BITS   = vna_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  vna_pkg::dp_cmd_t                  cmd,
  output vna_pkg::dp_status_t               status,
  input  logic [vna_pkg::IDX_W-1:0]         vertex_index,
  input  logic signed [vna_pkg::POS_W-1:0]  pos_x,
  input  logic signed [vna_pkg::POS_W-1:0]  pos_y,
  input  logic signed [vna_pkg::POS_W-1:0]  pos_z,
  input  logic [vna_pkg::IDX_W-1:0]         corner_a,
  input  logic [vna_pkg::IDX_W-1:0]         corner_b,
  input  logic [vna_pkg::IDX_W-1:0]         corner_c,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [vna_pkg::IDX_W-1:0]         out_vertex,
  output logic signed [vna_pkg::NRM_W-1:0]  normal_x,
  output logic signed [vna_pkg::NRM_W-1:0]  normal_y,
  output logic signed [vna_pkg::NRM_W-1:0]  normal_z,
  output logic                              degenerate,
  output logic                              last
);
  import vna_pkg::*;

  localparam int ADDR_W = $clog2(VERTEX_SLOTS);
  localparam int EDGE_W = POS_W + 1;
  localparam int PR_W   = 2 * EDGE_W;
  localparam int BP_W   = NRM_W + COUNT_BITS + 1;

  function automatic logic in_range(input logic [IDX_W-1:0] idx);
    return IDX_EXT_W'(idx) < IDX_EXT_W'(VERTEX_SLOTS);
  endfunction

  function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
    logic [IDX_EXT_W-1:0] e;
    e = IDX_EXT_W'(idx);
    return e[ADDR_W-1:0];
  endfunction

  logic [3*POS_W-1:0]      pos_mem [VERTEX_SLOTS];
  logic [3*NRM_W-1:0]      nrm_mem [VERTEX_SLOTS];
  logic [COUNT_BITS-1:0]   cnt_mem [VERTEX_SLOTS];
  logic [3*POS_W-1:0]      pos_q;
  logic [3*NRM_W-1:0]      nrm_q;
  logic [COUNT_BITS-1:0]   cnt_q;
  logic [COUNT_BITS-1:0]   cnt_new;
  logic [COUNT_BITS-1:0]   k_m1;
  logic [ADDR_W-1:0]       clr_addr;

  logic [IDX_W-1:0]        corner [3];
  logic                    range_ok;
  logic [IDX_W-1:0]        cur;
  logic [ADDR_W-1:0]       cur_addr;

  logic signed [POS_W-1:0]  pq [3];
  logic signed [POS_W-1:0]  pa [3];
  logic signed [POS_W-1:0]  pb [3];
  logic signed [EDGE_W-1:0] e1 [3];
  logic signed [EDGE_W-1:0] e2 [3];
  logic signed [PR_W-1:0]   pr [6];
  logic signed [NRM_W-1:0]  nq [3];
  logic signed [BP_W-1:0]   bp [3];
  logic signed [VEC_W-1:0]  vec [3];
  logic signed [NRM_W-1:0]  face [3];
  logic signed [NRM_W-1:0]  ures [3];
  logic                     unit_done, unit_zero;

  always_comb begin
    cur      = corner[cmd.corner];
    cur_addr = to_addr(cur);
    cnt_new  = (&cnt_q) ? cnt_q : cnt_q + COUNT_BITS'(1);
    for (int i = 0; i < 3; i++) begin
      pq[i] = pos_q[(2 - i) * POS_W +: POS_W];
      nq[i] = nrm_q[(2 - i) * NRM_W +: NRM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_range(vertex_index)) begin
      pos_mem[to_addr(vertex_index)] <= {pos_x, pos_y, pos_z};
    end
    if (cmd.pos_rd) begin
      pos_q <= pos_mem[cur_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.nrm_wr) begin
      if (cmd.nrm_from_unit) nrm_mem[cur_addr] <= {ures[0], ures[1], ures[2]};
      else                   nrm_mem[cur_addr] <= {face[0], face[1], face[2]};
    end
    if (cmd.corner_rd) begin
      nrm_q <= nrm_mem[cur_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      cnt_mem[clr_addr] <= '0;
    end else if (cmd.count_wr) begin
      cnt_mem[cur_addr] <= cnt_new;
    end
    if (cmd.corner_rd) begin
      cnt_q <= cnt_mem[cur_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step && !status.clear_done) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.face_latch) begin
      corner[0] <= corner_a;
      corner[1] <= corner_b;
      corner[2] <= corner_c;
      range_ok  <= in_range(corner_a) && in_range(corner_b) && in_range(corner_c);
    end
    if (cmd.save_pa) pa <= pq;
    if (cmd.save_pb) pb <= pq;
    if (cmd.edge_en) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= EDGE_W'(pa[i]) - EDGE_W'(pb[i]);
        e2[i] <= EDGE_W'(pa[i]) - EDGE_W'(pq[i]);
      end
    end
    if (cmd.prod_en) begin
      pr[0] <= e1[1] * e2[2];
      pr[1] <= e1[2] * e2[1];
      pr[2] <= e1[2] * e2[0];
      pr[3] <= e1[0] * e2[2];
      pr[4] <= e1[0] * e2[1];
      pr[5] <= e1[1] * e2[0];
    end
    if (cmd.count_wr) k_m1 <= cnt_new - COUNT_BITS'(1);
    if (cmd.blend_mul) begin
      for (int i = 0; i < 3; i++) bp[i] <= nq[i] * $signed({1'b0, k_m1});
    end
    if (cmd.cross_en) begin
      vec[0] <= VEC_W'(pr[0]) - VEC_W'(pr[1]);
      vec[1] <= VEC_W'(pr[2]) - VEC_W'(pr[3]);
      vec[2] <= VEC_W'(pr[4]) - VEC_W'(pr[5]);
    end else if (cmd.blend_add) begin
      for (int i = 0; i < 3; i++) vec[i] <= VEC_W'(bp[i]) + VEC_W'(face[i]);
    end
    if (cmd.face_save) face <= ures;
  end

  vna_unit u_unit (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.unit_start),
    .vec_x (vec[0]),
    .vec_y (vec[1]),
    .vec_z (vec[2]),
    .done  (unit_done),
    .zero  (unit_zero),
    .res_x (ures[0]),
    .res_y (ures[1]),
    .res_z (ures[2])
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_vertex <= cur;
      last       <= cmd.last;
      degenerate <= (cmd.src == SRC_ZERO);
      case (cmd.src)
        SRC_FACE: {normal_x, normal_y, normal_z} <= {face[0], face[1], face[2]};
        SRC_UNIT: {normal_x, normal_y, normal_z} <= {ures[0], ures[1], ures[2]};
        SRC_OLD:  {normal_x, normal_y, normal_z} <= {nq[0], nq[1], nq[2]};
        default:  {normal_x, normal_y, normal_z} <= '0;
      endcase
    end
  end

  always_comb begin
    status.clear_done = (clr_addr == ADDR_W'(VERTEX_SLOTS - 1));
    status.range_ok   = range_ok;
    status.unit_done  = unit_done;
    status.unit_zero  = unit_zero;
    status.first_use  = (cnt_q == '0);
    status.out_free   = !out_valid || !out_stall;
  end

endmodule

### rtl/vna_ctrl.sv
// ============================================================================
// vna_ctrl - controller of the vertex normal averager
// Sequences the count clearing sweep, position loads, the face normal and
// the per-corner update, and hands out one result per corner.
// ============================================================================
module vna_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 kind,
  output logic                 in_stall,
  input  vna_pkg::dp_status_t  status,
  output vna_pkg::dp_cmd_t     cmd
);
  import vna_pkg::*;

  ctrl_state_t state, state_next;
  logic [1:0]  j;
  src_t        src;

  always_comb begin
    state_next = state;
    unique case (state)
      C_CLEAR: if (status.clear_done) state_next = C_IDLE;
      C_IDLE:  if (in_valid && kind) state_next = C_CHECK;
      C_CHECK: state_next = status.range_ok ? C_RD_A : C_DEGEN;
      C_RD_A:  state_next = C_RD_B;
      C_RD_B:  state_next = C_RD_C;
      C_RD_C:  state_next = C_EDGE;
      C_EDGE:  state_next = C_PROD;
      C_PROD:  state_next = C_CROSS;
      C_CROSS: state_next = C_FGO;
      C_FGO:   state_next = C_FWAIT;
      C_FWAIT: begin
        if (status.unit_done) state_next = status.unit_zero ? C_DEGEN : C_CRD;
      end
      C_DEGEN: if (status.out_free && j == 2'd2) state_next = C_IDLE;
      C_CRD:   state_next = C_COUNT;
      C_COUNT: state_next = status.first_use ? C_EMIT : C_BMUL;
      C_BMUL:  state_next = C_BADD;
      C_BADD:  state_next = C_BGO;
      C_BGO:   state_next = C_BWAIT;
      C_BWAIT: if (status.unit_done) state_next = C_EMIT;
      C_EMIT: begin
        if (status.out_free) state_next = (j == 2'd2) ? C_IDLE : C_CRD;
      end
      default: state_next = C_CLEAR;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.corner = j;
    cmd.src    = src;
    cmd.last   = (j == 2'd2);
    in_stall   = (state != C_IDLE);
    unique case (state)
      C_CLEAR: cmd.clear_step = 1'b1;
      C_IDLE: begin
        cmd.load       = in_valid && !kind;
        cmd.face_latch = in_valid && kind;
      end
      C_RD_A: begin
        cmd.pos_rd = 1'b1;
        cmd.corner = 2'd0;
      end
      C_RD_B: begin
        cmd.pos_rd  = 1'b1;
        cmd.corner  = 2'd1;
        cmd.save_pa = 1'b1;
      end
      C_RD_C: begin
        cmd.pos_rd  = 1'b1;
        cmd.corner  = 2'd2;
        cmd.save_pb = 1'b1;
      end
      C_EDGE:  cmd.edge_en = 1'b1;
      C_PROD:  cmd.prod_en = 1'b1;
      C_CROSS: cmd.cross_en = 1'b1;
      C_FGO:   cmd.unit_start = 1'b1;
      C_FWAIT: cmd.face_save = status.unit_done && !status.unit_zero;
      C_DEGEN: begin
        cmd.emit = status.out_free;
        cmd.src  = SRC_ZERO;
      end
      C_CRD: cmd.corner_rd = 1'b1;
      C_COUNT: begin
        cmd.count_wr = 1'b1;
        cmd.nrm_wr   = status.first_use;
      end
      C_BMUL: cmd.blend_mul = 1'b1;
      C_BADD: cmd.blend_add = 1'b1;
      C_BGO:  cmd.unit_start = 1'b1;
      C_BWAIT: begin
        cmd.nrm_wr        = status.unit_done && !status.unit_zero;
        cmd.nrm_from_unit = 1'b1;
      end
      C_EMIT: cmd.emit = status.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_CLEAR;
      j     <= '0;
      src   <= SRC_ZERO;
    end else begin
      state <= state_next;
      if (state == C_IDLE) j <= '0;
      else if (cmd.emit) j <= j + 2'd1;
      if (state == C_COUNT && status.first_use) src <= SRC_FACE;
      else if (state == C_BWAIT && status.unit_done) begin
        src <= status.unit_zero ? SRC_OLD : SRC_UNIT;
      end
    end
  end

endmodule

### rtl/vertex_normal_averager.sv
// ============================================================================
// vertex_normal_averager - per-vertex normal averaging over mesh faces
// Loads vertex positions, forms unit face normals and folds them into a
// running average normal per vertex with a saturating use count.
// ============================================================================
//  channel  direction  handshake            payload
//  in       to block   in_valid / in_stall  kind, vertex_index, pos_x/y/z,
//                                           corner_a/b/c
//  out      from block out_valid/out_stall  out_vertex, normal_x/y/z,
//                                           degenerate, last
//
//  A face takes one unit pass, then per corner either stores the face normal
//  (first use) or blends it in another pass; a rejected face gives its three
//  items with no pass. A pass normalizes, sums the squares, takes the root and
//  divides; a zero vector ends after the normalize step.
//  After reset the use counts are cleared in a sweep over all slots while
//  in_stall is high. A stalled output holds the controller at that corner.
// ============================================================================
module vertex_normal_averager #(
  parameter int VERTEX_SLOTS = vna_pkg::VERTEX_SLOTS_DEF,
  parameter int COUNT_BITS   = vna_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic [vna_pkg::IDX_W-1:0]         vertex_index,
  input  logic signed [vna_pkg::POS_W-1:0]  pos_x,
  input  logic signed [vna_pkg::POS_W-1:0]  pos_y,
  input  logic signed [vna_pkg::POS_W-1:0]  pos_z,
  input  logic [vna_pkg::IDX_W-1:0]         corner_a,
  input  logic [vna_pkg::IDX_W-1:0]         corner_b,
  input  logic [vna_pkg::IDX_W-1:0]         corner_c,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [vna_pkg::IDX_W-1:0]         out_vertex,
  output logic signed [vna_pkg::NRM_W-1:0]  normal_x,
  output logic signed [vna_pkg::NRM_W-1:0]  normal_y,
  output logic signed [vna_pkg::NRM_W-1:0]  normal_z,
  output logic                              degenerate,
  output logic                              last
);
  import vna_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  vna_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  vna_dp #(
    .VERTEX_SLOTS (VERTEX_SLOTS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .vertex_index (vertex_index),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .corner_a     (corner_a),
    .corner_b     (corner_b),
    .corner_c     (corner_c),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_vertex   (out_vertex),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .degenerate   (degenerate),
    .last         (last)
  );

endmodule

### rtl/vna_checker.sv
// ============================================================================
// vna_checker - port-level checks for the vertex normal averager
// Watches the top-level ports and flags handshake and result slips.
// ============================================================================
module vna_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              kind,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [vna_pkg::IDX_W-1:0]         out_vertex,
  input logic signed [vna_pkg::NRM_W-1:0]  normal_x,
  input logic signed [vna_pkg::NRM_W-1:0]  normal_y,
  input logic signed [vna_pkg::NRM_W-1:0]  normal_z,
  input logic                              degenerate,
  input logic                              last
);

  a_reset_stalls: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input not stalled after reset");

  a_face_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && kind |=> in_stall)
    else $error("face item did not occupy the block");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> normal_x == 0 && normal_y == 0 && normal_z == 0)
    else $error("degenerate item carries a nonzero normal");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_vertex) && $stable(normal_x)
      && $stable(normal_y) && $stable(normal_z) && $stable(degenerate) && $stable(last))
    else $error("stalled output item changed");

endmodule

bind vertex_normal_averager vna_checker u_vna_checker (.*);

### dv/vertex_normal_checker.sv
// ----------------------------------------------------------------------------
// vertex_normal_checker
// Watches both channels of the vertex normal averager, keeps its own copy of
// the position, normal and use-count stores, predicts the three corner
// results of every accepted face item, and compares them in order.
// ----------------------------------------------------------------------------
module vertex_normal_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              kind,
  input  logic [9:0]        vertex_index,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  input  logic [9:0]        corner_a,
  input  logic [9:0]        corner_b,
  input  logic [9:0]        corner_c,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [9:0]        out_vertex,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic              degenerate,
  input  logic              last,
  output int                fail_count,
  output int                pending
);
  localparam int SLOTS = 1024;
  localparam int CMAX  = 255;

  typedef struct {
    logic [9:0]  vtx;
    logic [15:0] nx, ny, nz;
    logic        degen, lst;
  } corner_result_t;

  corner_result_t expected_q[$];
  int  px[SLOTS], py[SLOTS], pz[SLOTS];
  int  nrm_x[SLOTS], nrm_y[SLOTS], nrm_z[SLOTS];
  int  uses[SLOTS];

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // unit length in Q1.14; returns 0 for a zero vector
  function automatic bit to_unit(input longint v0, v1, v2, output int o0, o1, o2);
    longint unsigned m[3], mx, s, r, q;
    bit neg[3];
    longint v[3];
    int o[3];
    v[0] = v0; v[1] = v1; v[2] = v2;
    mx = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      m[i] = neg[i] ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return 0;
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      mx <<= 1;
    end
    for (int i = 0; i < 3; i++) s += m[i] * m[i];
    r = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 14) + (r >> 1)) / r;
      o[i] = neg[i] ? -int'(q) : int'(q);
    end
    o0 = o[0]; o1 = o[1]; o2 = o[2];
    return 1;
  endfunction

  task automatic predict_face(input logic [9:0] ca, cb, cc);
    logic [9:0] cn[3];
    longint e1[3], e2[3];
    int fx, fy, fz, tx, ty, tz, v;
    bit ok;
    corner_result_t res;
    cn[0] = ca; cn[1] = cb; cn[2] = cc;
    e1[0] = longint'(px[ca]) - longint'(px[cb]);
    e1[1] = longint'(py[ca]) - longint'(py[cb]);
    e1[2] = longint'(pz[ca]) - longint'(pz[cb]);
    e2[0] = longint'(px[ca]) - longint'(px[cc]);
    e2[1] = longint'(py[ca]) - longint'(py[cc]);
    e2[2] = longint'(pz[ca]) - longint'(pz[cc]);
    ok = to_unit(e1[1] * e2[2] - e1[2] * e2[1], e1[2] * e2[0] - e1[0] * e2[2],
                 e1[0] * e2[1] - e1[1] * e2[0], fx, fy, fz);
    for (int j = 0; j < 3; j++) begin
      v = cn[j];
      res.vtx = cn[j];
      res.lst = (j == 2);
      res.degen = !ok;
      if (!ok) begin
        res.nx = '0; res.ny = '0; res.nz = '0;
      end else begin
        if (uses[v] < CMAX) uses[v]++;
        if (uses[v] == 1) begin
          nrm_x[v] = fx; nrm_y[v] = fy; nrm_z[v] = fz;
        end else if (to_unit(longint'(nrm_x[v]) * (uses[v] - 1) + fx,
                             longint'(nrm_y[v]) * (uses[v] - 1) + fy,
                             longint'(nrm_z[v]) * (uses[v] - 1) + fz, tx, ty, tz)) begin
          nrm_x[v] = tx; nrm_y[v] = ty; nrm_z[v] = tz;
        end
        res.nx = 16'(nrm_x[v]); res.ny = 16'(nrm_y[v]); res.nz = 16'(nrm_z[v]);
      end
      expected_q = {expected_q, res};
    end
  endtask

  always @(posedge clk) begin
    corner_result_t e;
    if (rst) begin
      fail_count <= 0;
      pending <= 0;
      expected_q.delete();
      for (int i = 0; i < SLOTS; i++) uses[i] = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (!kind) begin
          px[vertex_index] = pos_x;
          py[vertex_index] = pos_y;
          pz[vertex_index] = pos_z;
        end else begin
          predict_face(corner_a, corner_b, corner_c);
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result for vertex %0d", out_vertex);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_vertex !== e.vtx || normal_x !== e.nx || normal_y !== e.ny ||
              normal_z !== e.nz || degenerate !== e.degen || last !== e.lst) begin
            fail_count <= fail_count + 1;
            if (out_vertex !== e.vtx)
              $error("out_vertex expected %0d got %0d", e.vtx, out_vertex);
            if (normal_x !== e.nx)
              $error("normal_x expected %0d got %0d", $signed(e.nx), normal_x);
            if (normal_y !== e.ny)
              $error("normal_y expected %0d got %0d", $signed(e.ny), normal_y);
            if (normal_z !== e.nz)
              $error("normal_z expected %0d got %0d", $signed(e.nz), normal_z);
            if (degenerate !== e.degen)
              $error("degenerate expected %0b got %0b", e.degen, degenerate);
            if (last !== e.lst)
              $error("last expected %0b got %0b", e.lst, last);
          end
        end
      end
      pending <= expected_q.size();
    end
  end
endmodule

### dv/vertex_normal_averager_test.sv
// ----------------------------------------------------------------------------
// vertex_normal_averager_test
// Drives load and face items through the averager with bursty input and a
// random output stall: directed faces for degenerate, top-slot corners,
// repeated corners, cancelling blends and repeated blends, then random
// meshes over a small written vertex pool. The checker compares every result.
// ----------------------------------------------------------------------------
module vertex_normal_averager_test;
  import vna_pkg::*;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_FACE = 1'b1;

  logic clk, rst;
  logic in_valid, in_stall, kind;
  logic [9:0] vertex_index, corner_a, corner_b, corner_c;
  logic signed [15:0] pos_x, pos_y, pos_z;
  logic out_valid, out_stall;
  logic [9:0] out_vertex;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic degenerate, last;
  int fail_count, pending;
  int gap_left;
  bit written[1024];
  int pool[$];

  vertex_normal_averager uut (.*);
  vertex_normal_checker chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver stall: alternates between calm stretches and busy ones
  int stall_phase;
  always @(posedge clk) begin
    if (rst) begin
      stall_phase <= 0;
      out_stall <= 1'b0;
    end else begin
      stall_phase <= (stall_phase + 1) % 400;
      if (stall_phase < 150) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 2) == 0);
    end
  end

  task automatic send(input logic k, input logic [9:0] vi, input logic [15:0] x, y, z,
                      input logic [9:0] a, b, c);
    int idle;
    if (gap_left == 0) begin
      gap_left = $urandom_range(1, 8);
      idle = $urandom_range(0, 30);
      if (idle != 0) begin
        in_valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
    gap_left--;
    in_valid <= 1'b1;
    kind <= k; vertex_index <= vi; pos_x <= x; pos_y <= y; pos_z <= z;
    corner_a <= a; corner_b <= b; corner_c <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (k == KIND_LOAD) written[vi] = 1'b1;
  endtask

  task automatic load_vertex(input logic [9:0] vi, input logic [15:0] x, y, z);
    send(KIND_LOAD, vi, x, y, z, 10'($urandom), 10'($urandom), 10'($urandom));
  endtask

  task automatic face(input logic [9:0] a, b, c);
    send(KIND_FACE, 10'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), a, b, c);
  endtask

  function automatic logic [9:0] pick();
    return 10'(pool[$urandom_range(0, pool.size() - 1)]);
  endfunction

  initial begin
    int v;
    gap_left = 0;
    in_valid = 0; kind = 0; vertex_index = 0; pos_x = 0; pos_y = 0; pos_z = 0;
    corner_a = 0; corner_b = 0; corner_c = 0;
    rst = 1;
    repeat (7) @(posedge clk);
    rst <= 0;

    // directed
    load_vertex(0, 16'sh7fff, 16'sh8000, 0);
    load_vertex(1, 16'sh8000, 16'sh7fff, 16'sh7fff);
    load_vertex(2, 16'sh8000, 16'sh8000, 16'sh8000);
    load_vertex(1023, 16'h0000, 16'h0000, 16'h1000);
    load_vertex(3, 16'h1000, 0, 0);
    load_vertex(4, 0, 16'h1000, 0);
    load_vertex(5, 16'h2000, 0, 0);
    face(0, 1, 2);
    face(1023, 3, 4);
    face(3, 3, 4);          // zero area, repeated corner
    face(1023, 3, 5);       // not collinear: 1023 lies off the line of 3 and 5
    face(1023, 4, 3);       // opposite winding: blend cancels
    face(1023, 4, 3);
    face(3, 4, 3);          // corner named twice
    repeat (4) face(0, 1, 2);  // blends with growing counts
    face(0, 2, 1);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);  // full drain before random part

    for (int i = 0; i < 1024; i++) if (written[i]) pool = {pool, i};
    for (int i = 0; i < 80; i++) begin
      if ($urandom_range(0, 3) == 0 || pool.size() < 3) begin
        v = $urandom_range(0, 1023);
        if (!written[v]) pool = {pool, v};
        load_vertex(10'(v), 16'($urandom), 16'($urandom), 16'($urandom));
      end else if ($urandom_range(0, 9) == 0) begin
        face(pick(), pick(), pick());
      end else begin
        v = pool.size() - 1;
        face(10'(pool[$urandom_range(0, v)]), 10'(pool[$urandom_range(0, v)]),
             10'(pool[$urandom_range(0, v)]));
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
